### rtl/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types and constants for the frame pool table.
// ----------------------------------------------------------------------------
package fpt_pkg;

  localparam int NumFrames = 1024;
  localparam int FrameW    = $clog2(NumFrames);
  localparam int CountW    = FrameW + 1;
  localparam int PoolW     = 2;
  localparam int NumPools  = 4;
  localparam int SlotAw    = PoolW + FrameW;
  localparam int FrameMemW = PoolW + FrameW;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MOVE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_POOL  = 2'd2,
    ST_WAS_FREE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POOL_FREE    = 2'd0,
    POOL_DEFAULT = 2'd1,
    POOL_RECYCLE = 2'd2,
    POOL_KEEP    = 2'd3
  } pool_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SWAP,
    S_APPEND,
    S_DONE
  } state_e;

endpackage

### rtl/fpt_ram.sv
// ----------------------------------------------------------------------------
// fpt_ram
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module fpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/frame_pool_table_unit.sv
// ----------------------------------------------------------------------------
// frame_pool_table_unit
// Frame table sorting frames into free, default, recycle and keep pools.
// ----------------------------------------------------------------------------
// After reset the unit loads all NumFrames (1024) frame memory entries and
// free-pool slots with busy high. After that, a command is taken when start
// is high and busy is low. Its result appears on done_o for one cycle. The
// next command can be taken in the cycle after the result. From one
// accepted command to the next, the unit runs through these states:
// - straight to done for an allocate or move to the free pool, an allocate
//   with no free frame, or a no-op.
// - read, then done, for a free of a frame that is already free, or a move
//   to the frame's own pool.
// - read, append, done for an allocate, or for a free or move without a swap.
// - read, swap, append, done for a free or move with a swap.
// The states follow from the dependent reads of the frame memory (tag and
// position) and slot memory (last slot), each through a registered read port,
// followed by write-back. busy stays high until the result cycle is over;
// the receiver cannot stall the result.
// ----------------------------------------------------------------------------
module frame_pool_table_unit
  import fpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic [FrameW-1:0] frame_in_i,
  input  logic [PoolW-1:0]  target_pool_i,
  output logic              done_o,
  output logic [FrameW-1:0] frame_out_o,
  output logic [1:0]        status_o,
  output logic [CountW-1:0] free_count_o,
  output logic [CountW-1:0] default_count_o,
  output logic [CountW-1:0] recycle_count_o,
  output logic [CountW-1:0] keep_count_o
);

  state_e state_q, state_d;
  logic [FrameW-1:0] clr_q, clr_d;
  logic [CountW-1:0] cnt_q [NumPools];
  logic [CountW-1:0] cnt_d [NumPools];
  cmd_e              cmd_q, cmd_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [PoolW-1:0]  tgt_q, tgt_d;
  logic [PoolW-1:0]  pool_q, pool_d;
  logic [PoolW-1:0]  dst_q, dst_d;
  logic [FrameW-1:0] pos_q, pos_d;
  logic [FrameW-1:0] fr_q, fr_d;
  logic [FrameW-1:0] fout_q, fout_d;
  status_e           status_q, status_d;

  logic                 fm_we, sl_we;
  logic [FrameW-1:0]    fm_waddr, fm_raddr;
  logic [FrameMemW-1:0] fm_wdata, fm_rdata;
  logic [SlotAw-1:0]    sl_waddr, sl_raddr;
  logic [FrameW-1:0]    sl_wdata, sl_rdata;
  logic [PoolW-1:0]     rd_tag;
  logic [FrameW-1:0]    rd_pos;
  logic [CountW-1:0]    last_cnt;

  // Frame memory: {pool tag, position}
  fpt_ram #(.Width(FrameMemW), .Depth(NumFrames)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (fm_waddr),
    .wdata_i (fm_wdata),
    .raddr_i (fm_raddr),
    .rdata_o (fm_rdata)
  );

  // Slot memory: {pool, index} -> frame
  fpt_ram #(.Width(FrameW), .Depth(NumPools * NumFrames)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .raddr_i (sl_raddr),
    .rdata_o (sl_rdata)
  );

  assign rd_tag   = fm_rdata[FrameMemW-1:FrameW];
  assign rd_pos   = fm_rdata[FrameW-1:0];
  assign last_cnt = cnt_q[rd_tag] - CountW'(1);

  // Control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q[0] <= CountW'(NumFrames);
      for (int i = 1; i < NumPools; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    frame_q  <= frame_d;
    tgt_q    <= tgt_d;
    pool_q   <= pool_d;
    dst_q    <= dst_d;
    pos_q    <= pos_d;
    fr_q     <= fr_d;
    fout_q   <= fout_d;
    status_q <= status_d;
  end

  // Sequencer: read, check, swap-remove, append
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cnt_d    = cnt_q;
    cmd_d    = cmd_q;
    frame_d  = frame_q;
    tgt_d    = tgt_q;
    pool_d   = pool_q;
    dst_d    = dst_q;
    pos_d    = pos_q;
    fr_d     = fr_q;
    fout_d   = fout_q;
    status_d = status_q;
    fm_we    = 1'b0;
    fm_waddr = '0;
    fm_wdata = '0;
    fm_raddr = frame_in_i;
    sl_we    = 1'b0;
    sl_waddr = '0;
    sl_wdata = '0;
    sl_raddr = {POOL_FREE, FrameW'(cnt_q[POOL_FREE] - CountW'(1))};

    case (state_q)
      S_CLEAR: begin
        // Load reset contents one frame per cycle
        fm_we    = 1'b1;
        fm_waddr = clr_q;
        fm_wdata = {POOL_FREE, FrameW'(NumFrames - 1) - clr_q};
        sl_we    = 1'b1;
        sl_waddr = {POOL_FREE, clr_q};
        sl_wdata = FrameW'(NumFrames - 1) - clr_q;
        clr_d    = clr_q + FrameW'(1);
        if (clr_q == FrameW'(NumFrames - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_d    = cmd_e'(cmd_i);
          frame_d  = frame_in_i;
          tgt_d    = target_pool_i;
          status_d = ST_OK;
          fout_d   = frame_in_i;
          state_d  = S_DONE;
          case (cmd_e'(cmd_i))
            CMD_ALLOC: begin
              fout_d = '0;
              if (target_pool_i == POOL_FREE) begin
                status_d = ST_BAD_POOL;
              end else if (cnt_q[POOL_FREE] == '0) begin
                status_d = ST_NO_FREE;
              end else begin
                state_d = S_READ;
              end
            end
            CMD_FREE: begin
              state_d = S_READ;
            end
            CMD_MOVE: begin
              if (target_pool_i == POOL_FREE) begin
                status_d = ST_BAD_POOL;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        if (cmd_q == CMD_ALLOC) begin
          // Top of free pool sits at its last slot: no swap needed
          fr_d   = sl_rdata;
          fout_d = sl_rdata;
          dst_d  = tgt_q;
          cnt_d[POOL_FREE] = cnt_q[POOL_FREE] - CountW'(1);
          state_d = S_APPEND;
        end else if (cmd_q == CMD_FREE && rd_tag == POOL_FREE) begin
          status_d = ST_WAS_FREE;
          state_d  = S_DONE;
        end else if (cmd_q == CMD_MOVE && rd_tag == tgt_q) begin
          state_d = S_DONE;
        end else begin
          fr_d   = frame_q;
          pool_d = rd_tag;
          pos_d  = rd_pos;
          dst_d  = (cmd_q == CMD_FREE) ? POOL_FREE : tgt_q;
          cnt_d[rd_tag] = last_cnt;
          sl_raddr = {rd_tag, last_cnt[FrameW-1:0]};
          state_d  = (rd_pos != last_cnt[FrameW-1:0]) ? S_SWAP : S_APPEND;
        end
      end
      S_SWAP: begin
        // Fill the hole with the last frame and fix its position
        sl_we    = 1'b1;
        sl_waddr = {pool_q, pos_q};
        sl_wdata = sl_rdata;
        fm_we    = 1'b1;
        fm_waddr = sl_rdata;
        fm_wdata = {pool_q, pos_q};
        state_d  = S_APPEND;
      end
      S_APPEND: begin
        sl_we    = 1'b1;
        sl_waddr = {dst_q, cnt_q[dst_q][FrameW-1:0]};
        sl_wdata = fr_q;
        fm_we    = 1'b1;
        fm_waddr = fr_q;
        fm_wdata = {dst_q, cnt_q[dst_q][FrameW-1:0]};
        cnt_d[dst_q] = cnt_q[dst_q] + CountW'(1);
        state_d  = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign frame_out_o     = fout_q;
  assign status_o        = status_q;
  assign free_count_o    = cnt_q[POOL_FREE];
  assign default_count_o = cnt_q[POOL_DEFAULT];
  assign recycle_count_o = cnt_q[POOL_RECYCLE];
  assign keep_count_o    = cnt_q[POOL_KEEP];

endmodule

### rtl/fpt_checker.sv
// ----------------------------------------------------------------------------
// fpt_checker
// Port-level checks for the frame pool table, bound to the top level.
// ----------------------------------------------------------------------------
module fpt_checker
  import fpt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [1:0]        status_o,
  input logic [CountW-1:0] free_count_o,
  input logic [CountW-1:0] default_count_o,
  input logic [CountW-1:0] recycle_count_o,
  input logic [CountW-1:0] keep_count_o
);

  // An accepted transfer keeps the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // The result strobe releases the unit
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result");

  // Every frame sits in exactly one pool
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(free_count_o) + 32'(default_count_o) + 32'(recycle_count_o)
                + 32'(keep_count_o) == 32'(NumFrames)))
    else $error("pool counts do not add up");

  // No-free status only with an empty free pool
  a_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_NO_FREE) |-> (free_count_o == '0))
    else $error("no-free status with free frames");

endmodule

bind frame_pool_table_unit fpt_checker u_fpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .free_count_o    (free_count_o),
  .default_count_o (default_count_o),
  .recycle_count_o (recycle_count_o),
  .keep_count_o    (keep_count_o)
);

### sim/frame_pool_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_pool_table_checker
// Watches command and result transfers of the frame pool table, keeps its
// own copy of the pools, and compares every result field by field.
// ----------------------------------------------------------------------------
module frame_pool_table_checker
  import fpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        cmd_i,
  input  logic [FrameW-1:0] frame_in_i,
  input  logic [PoolW-1:0]  target_pool_i,
  input  logic              done_i,
  input  logic [FrameW-1:0] frame_out_i,
  input  logic [1:0]        status_i,
  input  logic [CountW-1:0] free_count_i,
  input  logic [CountW-1:0] default_count_i,
  input  logic [CountW-1:0] recycle_count_i,
  input  logic [CountW-1:0] keep_count_i,
  output int                pending_o,
  output int                errors_o
);

  typedef struct packed {
    logic [FrameW-1:0] frame;
    status_e           status;
    logic [CountW-1:0] cnt_free;
    logic [CountW-1:0] cnt_default;
    logic [CountW-1:0] cnt_recycle;
    logic [CountW-1:0] cnt_keep;
  } pool_result_t;

  pool_result_t      results_q[$];
  pool_e             tag_mem[NumFrames];
  logic [FrameW-1:0] pos_mem[NumFrames];
  logic [FrameW-1:0] slot_mem[NumPools][NumFrames];
  logic [CountW-1:0] pool_cnt[NumPools];

  // Rebuild the reset contents of the table
  task automatic reset_pools();
    for (int i = 0; i < NumFrames; i++) begin
      tag_mem[i] = POOL_FREE;
      pos_mem[i] = FrameW'(NumFrames - 1 - i);
      slot_mem[POOL_FREE][i] = FrameW'(NumFrames - 1 - i);
    end
    pool_cnt[POOL_FREE]    = CountW'(NumFrames);
    pool_cnt[POOL_DEFAULT] = '0;
    pool_cnt[POOL_RECYCLE] = '0;
    pool_cnt[POOL_KEEP]    = '0;
  endtask

  // Swap-remove a frame from its pool, then append it to the destination
  function automatic void relocate_frame(logic [FrameW-1:0] f, pool_e src, pool_e dst);
    logic [FrameW-1:0] pos;
    logic [FrameW-1:0] last;
    logic [FrameW-1:0] moved;
    pos = pos_mem[f];
    if (pool_cnt[src] > 0) begin
      last = FrameW'(pool_cnt[src] - 1);
      if (pos != last) begin
        moved = slot_mem[src][last];
        slot_mem[src][pos] = moved;
        pos_mem[moved] = pos;
      end
      pool_cnt[src] = pool_cnt[src] - 1;
    end
    if (pool_cnt[dst] < NumFrames) begin
      slot_mem[dst][pool_cnt[dst]] = f;
      pos_mem[f] = FrameW'(pool_cnt[dst]);
      pool_cnt[dst] = pool_cnt[dst] + 1;
    end
    tag_mem[f] = dst;
  endfunction

  // Apply one command and return what the table should report
  function automatic pool_result_t apply_command(cmd_e c, logic [FrameW-1:0] f,
                                                 pool_e tgt);
    pool_result_t r;
    r.frame  = f;
    r.status = ST_OK;
    case (c)
      CMD_ALLOC: begin
        r.frame = '0;
        if (tgt == POOL_FREE) r.status = ST_BAD_POOL;
        else if (pool_cnt[POOL_FREE] == 0) r.status = ST_NO_FREE;
        else begin
          r.frame = slot_mem[POOL_FREE][pool_cnt[POOL_FREE] - 1];
          relocate_frame(r.frame, POOL_FREE, tgt);
        end
      end
      CMD_FREE: begin
        if (tag_mem[f] == POOL_FREE) r.status = ST_WAS_FREE;
        else relocate_frame(f, tag_mem[f], POOL_FREE);
      end
      CMD_MOVE: begin
        if (tgt == POOL_FREE) r.status = ST_BAD_POOL;
        else if (tag_mem[f] != tgt) relocate_frame(f, tag_mem[f], tgt);
      end
      default: ;
    endcase
    r.cnt_free    = pool_cnt[POOL_FREE];
    r.cnt_default = pool_cnt[POOL_DEFAULT];
    r.cnt_recycle = pool_cnt[POOL_RECYCLE];
    r.cnt_keep    = pool_cnt[POOL_KEEP];
    return r;
  endfunction

  initial begin
    errors_o = 0;
    reset_pools();
  end

  assign pending_o = results_q.size();

  // Predict on each command transfer, compare on each result transfer
  always @(posedge clk_i) begin
    pool_result_t exp_r;
    pool_result_t act_r;
    if (rst_ni) begin
      if (done_i) begin
        act_r = {frame_out_i, status_e'(status_i), free_count_i, default_count_i,
                 recycle_count_i, keep_count_i};
        if (results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, act_r);
          errors_o++;
        end else begin
          exp_r = results_q.pop_front();
          if (act_r.frame !== exp_r.frame) begin
            $display("%0t: frame_out expected %0d actual %0d", $time, exp_r.frame,
                     act_r.frame);
            errors_o++;
          end
          if (act_r.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     act_r.status);
            errors_o++;
          end
          if (act_r.cnt_free !== exp_r.cnt_free) begin
            $display("%0t: free_count expected %0d actual %0d", $time,
                     exp_r.cnt_free, act_r.cnt_free);
            errors_o++;
          end
          if (act_r.cnt_default !== exp_r.cnt_default) begin
            $display("%0t: default_count expected %0d actual %0d", $time,
                     exp_r.cnt_default, act_r.cnt_default);
            errors_o++;
          end
          if (act_r.cnt_recycle !== exp_r.cnt_recycle) begin
            $display("%0t: recycle_count expected %0d actual %0d", $time,
                     exp_r.cnt_recycle, act_r.cnt_recycle);
            errors_o++;
          end
          if (act_r.cnt_keep !== exp_r.cnt_keep) begin
            $display("%0t: keep_count expected %0d actual %0d", $time,
                     exp_r.cnt_keep, act_r.cnt_keep);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i)
        results_q.push_back(apply_command(cmd_e'(cmd_i), frame_in_i,
                                          pool_e'(target_pool_i)));
    end
  end

endmodule

### sim/frame_pool_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_pool_table_unit_tb
// Drives directed and random allocate, free, move and no-op commands into the
// frame pool table; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module frame_pool_table_unit_tb;
  import fpt_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int RandomItems   = 807;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        cmd_i;
  logic [FrameW-1:0] frame_in_i;
  logic [PoolW-1:0]  target_pool_i;
  logic              done_o;
  logic [FrameW-1:0] frame_out_o;
  logic [1:0]        status_o;
  logic [CountW-1:0] free_count_o;
  logic [CountW-1:0] default_count_o;
  logic [CountW-1:0] recycle_count_o;
  logic [CountW-1:0] keep_count_o;
  int                pending;
  int                errors;
  int                idle_cycles;
  logic              calm;

  frame_pool_table_unit dut (.*);

  frame_pool_table_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cmd_i, .frame_in_i,
    .target_pool_i, .done_i(done_o), .frame_out_i(frame_out_o), .status_i(status_o),
    .free_count_i(free_count_o), .default_count_i(default_count_o),
    .recycle_count_i(recycle_count_o), .keep_count_i(keep_count_o),
    .pending_o(pending), .errors_o(errors)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hold a command until the table takes it, with random gaps in front
  task automatic send_command(cmd_e c, logic [FrameW-1:0] f, logic [PoolW-1:0] tgt);
    while (!calm && $urandom_range(99) < 22) @(posedge clk_i);
    start         <= 1'b1;
    cmd_i         <= c;
    frame_in_i    <= f;
    target_pool_i <= tgt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    // The table stays busy after it accepts a transfer
    @(posedge clk_i);
  endtask

  initial begin
    logic [FrameW-1:0] f;
    int                r;
    idle_cycles   = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    cmd_i         = CMD_NOP;
    frame_in_i    = '0;
    target_pool_i = POOL_FREE;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad pools, every command, own-pool move, free of free frame
    send_command(CMD_ALLOC, '1, POOL_FREE);
    send_command(CMD_ALLOC, '0, POOL_DEFAULT);
    send_command(CMD_ALLOC, '1, POOL_RECYCLE);
    send_command(CMD_ALLOC, '0, POOL_KEEP);
    send_command(CMD_FREE, 10'd1023, POOL_FREE);
    send_command(CMD_FREE, 10'd0, POOL_DEFAULT);
    send_command(CMD_FREE, 10'd0, POOL_DEFAULT);
    send_command(CMD_MOVE, 10'd1, POOL_FREE);
    send_command(CMD_MOVE, 10'd1, POOL_KEEP);
    send_command(CMD_MOVE, 10'd2, POOL_RECYCLE);
    send_command(CMD_MOVE, 10'd1023, POOL_DEFAULT);
    send_command(CMD_MOVE, 10'd1023, POOL_RECYCLE);
    send_command(CMD_MOVE, 10'd1, POOL_KEEP);
    send_command(CMD_NOP, 10'h2aa, 2'd1);
    send_command(CMD_NOP, 10'h155, 2'd2);
    send_command(CMD_FREE, 10'd2, POOL_FREE);
    send_command(CMD_FREE, 10'd1023, POOL_FREE);

    // Hold off until the table has drained its results
    while (pending != 0) @(posedge clk_i);

    // Drain the free pool completely, then hit the empty case
    calm = 1'b1;
    for (int i = 0; i < NumFrames; i++)
      send_command(CMD_ALLOC, 10'($urandom), 2'($urandom_range(3, 1)));
    send_command(CMD_ALLOC, '1, POOL_KEEP);
    send_command(CMD_ALLOC, '0, POOL_DEFAULT);
    calm = 1'b0;

    // Random traffic of allocates, frees and moves on random frames, plus random commands
    for (int i = 0; i < RandomItems; i++) begin
      if (i > 300 && i < 500) calm = 1'b1;
      else calm = 1'b0;
      r = $urandom_range(99);
      f = 10'($urandom);
      if (r < 30) send_command(CMD_ALLOC, f, 2'($urandom_range(3, 1)));
      else if (r < 60) send_command(CMD_FREE, f, 2'($urandom));
      else if (r < 90) send_command(CMD_MOVE, f, 2'($urandom_range(3, 1)));
      else send_command(cmd_e'($urandom_range(3)), f, 2'($urandom));
    end

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
